// ----- design/qpsk_pkg.sv -----
// Shared types, constants and the cosine table generator for the QPSK carrier modulator.
// Used by qpsk_ctrl, qpsk_datapath and qpsk_carrier_modulator_core; depends on nothing.
package qpsk_pkg;

    localparam int DEF_MAX_SAMPLES     = 32;
    localparam int DEF_TABLE_ADDR_BITS = 10;
    localparam int DEF_SAMPLE_BITS     = 16;

    // Configuration register indexes.
    localparam logic [1:0] REG_PHASE_STEP = 2'd0;
    localparam logic [1:0] REG_AMPLITUDE  = 2'd1;
    localparam logic [1:0] REG_SPS        = 2'd2;

    localparam int CFG_DATA_BITS = 32;
    localparam int AMP_BITS      = 15;
    localparam int SPS_BITS      = 6;
    localparam int MAG_BITS      = 15;

    localparam logic [31:0]         RST_PHASE_STEP = 32'd0;
    localparam logic [AMP_BITS-1:0] RST_AMPLITUDE  = 15'd32767;
    localparam logic [SPS_BITS-1:0] RST_SPS        = 6'd30;

    // Phase offsets of the four symbols, as 0.32 fractions of a cycle.
    localparam logic [31:0] OFFSET_00 = 32'h2000_0000;
    localparam logic [31:0] OFFSET_01 = 32'hE000_0000;
    localparam logic [31:0] OFFSET_10 = 32'h6000_0000;
    localparam logic [31:0] OFFSET_11 = 32'hA000_0000;

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

    // Taylor series denominators (2n-1)*(2n) for n = 1..10.
    localparam logic [63:0] TAYLOR_DIV [1:10] =
        '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
          64'd132, 64'd182, 64'd240, 64'd306, 64'd380};

    typedef struct packed {
        logic load;
        logic first_bit;
        logic second_bit;
        logic issue;
        logic last;
    } qpsk_cmd_t;

    typedef struct packed {
        logic ready;
    } qpsk_stat_t;

    // First-quadrant cosine in Q15 for table step m out of 2^(addr_bits-2).
    // Only evaluated at elaboration to build the constant table.
    function automatic logic [MAG_BITS-1:0] quarter_cos(input int unsigned m,
                                                        input int addr_bits);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] acc;
        logic [63:0]        r;
        x    = (64'(m) * Q30_HALF_PI) >> (addr_bits - 2);
        x2   = (x * x) >> 30;
        term = Q30_ONE;
        acc  = $signed(Q30_ONE);
        for (int n = 1; n <= 10; n++)
        begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[n];
            if ((n % 2) == 1)
                acc = acc - $signed(term);
            else
                acc = acc + $signed(term);
        end
        if (acc < 0)
            acc = 64'sd0;
        if (acc > $signed(Q30_ONE))
            acc = $signed(Q30_ONE);
        r = ($unsigned(acc) + 64'd16384) >> 15;
        if (r > 64'd32767)
            r = 64'd32767;
        return r[MAG_BITS-1:0];
    endfunction

endpackage

// ----- design/qpsk_carrier_modulator_core.sv -----
// QPSK carrier modulator top level: configuration registers, sequencer and sample pipeline.
// Each issued sample passes the address, index, magnitude, product and output registers.
// Throughput: one sample per cycle, set by the single sample issue slot of the sequencer; a symbol
// has samples_per_symbol samples (1..MAX_SAMPLES). Output stalls hold the whole pipe.
// Reset (rst_n, asynchronous, active low) clears the phase and loads the register defaults.
// Depends on qpsk_pkg, qpsk_ctrl and qpsk_datapath.
module qpsk_carrier_modulator_core
    import qpsk_pkg::*;
#(
    parameter int MAX_SAMPLES     = DEF_MAX_SAMPLES,
    parameter int TABLE_ADDR_BITS = DEF_TABLE_ADDR_BITS,
    parameter int SAMPLE_BITS     = DEF_SAMPLE_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          first_bit,
    input  logic                          second_bit,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] sample,
    output logic                          last_sample
);

    // Configuration registers. Writes are to be made only while the block is idle (the block
    // does not enforce this), so the sequencer and the pipeline can read them directly with no shadowing.
    logic [31:0]         phase_step_reg;
    logic [AMP_BITS-1:0] amplitude_reg;
    logic [SPS_BITS-1:0] sps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= RST_PHASE_STEP;
            amplitude_reg  <= RST_AMPLITUDE;
            sps_reg        <= RST_SPS;
        end
        else if (cfg_we)
        begin
            // Writes to an index past the last register are dropped.
            case (cfg_index)
                REG_PHASE_STEP: phase_step_reg <= cfg_data[31:0];
                REG_AMPLITUDE:  amplitude_reg  <= cfg_data[AMP_BITS-1:0];
                REG_SPS:        sps_reg        <= cfg_data[SPS_BITS-1:0];
                default:        ;
            endcase
        end
    end

    qpsk_cmd_t  cmd;
    qpsk_stat_t stat;

    // The sequencer accepts a symbol when idle, or in the same cycle that it issues
    // the last sample of the current symbol, so symbols run back to back without a gap.
    qpsk_ctrl #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .first_bit  (first_bit),
        .second_bit (second_bit),
        .sps        (sps_reg),
        .cmd        (cmd),
        .stat       (stat)
    );

    // The datapath owns the running phase. Each issued sample looks up the cosine
    // at phase plus symbol offset, scales it by the amplitude and lands in the
    // output register, which parts the pipeline from the output transfer.
    qpsk_datapath #(
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .phase_step  (phase_step_reg),
        .amplitude   (amplitude_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sample      (sample),
        .last_sample (last_sample)
    );

endmodule

// ----- design/qpsk_ctrl.sv -----
// Symbol sequencer for the QPSK carrier modulator: accepts symbols and issues samples.
// Depends on qpsk_pkg for the command and status structs.
module qpsk_ctrl
    import qpsk_pkg::*;
#(
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                first_bit,
    input  logic                second_bit,
    input  logic [SPS_BITS-1:0] sps,
    output qpsk_cmd_t           cmd,
    input  qpsk_stat_t          stat
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int CMP_W = (CNT_W > SPS_BITS) ? CNT_W : SPS_BITS;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic             state_reg;
    logic             state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CMP_W-1:0] sps_ext;
    logic [CNT_W-1:0] count_load;
    logic             issue;
    logic             last;
    logic             accept;

    // Zero samples per symbol means one; anything above the maximum is held at it.
    assign sps_ext = CMP_W'(sps);
    always_comb
    begin
        if (sps_ext == '0)
            count_load = CNT_W'(1);
        else if (sps_ext > CMP_W'(MAX_SAMPLES))
            count_load = CNT_W'(MAX_SAMPLES);
        else
            count_load = CNT_W'(sps_ext);
    end

    assign issue    = (state_reg == ST_RUN) && stat.ready;
    assign last     = (count_reg == CNT_W'(1));
    assign in_stall = !((state_reg == ST_IDLE) || (issue && last));
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        if (accept)
        begin
            state_next = ST_RUN;
            count_next = count_load;
        end
        else if (issue)
        begin
            if (last)
                state_next = ST_IDLE;
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    assign cmd.load       = accept;
    assign cmd.first_bit  = first_bit;
    assign cmd.second_bit = second_bit;
    assign cmd.issue      = issue;
    assign cmd.last       = last;

    a_load_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_RUN) && (count_reg != '0))
        else $error("symbol accepted without a nonzero sample count");

    a_idle_no_issue: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !cmd.issue)
        else $error("sample issued while idle");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && last && !accept) |=> (state_reg == ST_IDLE))
        else $error("run did not end after the last sample");

endmodule

// ----- design/qpsk_datapath.sv -----
// Phase accumulator, cosine lookup, amplitude scaling and output register of the modulator.
// Depends on qpsk_pkg for the cosine generator, offsets and command/status structs.
module qpsk_datapath
    import qpsk_pkg::*;
#(
    parameter int TABLE_ADDR_BITS = DEF_TABLE_ADDR_BITS,
    parameter int SAMPLE_BITS     = DEF_SAMPLE_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  qpsk_cmd_t                     cmd,
    output qpsk_stat_t                    stat,
    input  logic [31:0]                   phase_step,
    input  logic [AMP_BITS-1:0]           amplitude,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] sample,
    output logic                          last_sample
);

    localparam int A       = TABLE_ADDR_BITS;
    localparam int QW      = TABLE_ADDR_BITS - 2;
    localparam int QUARTER = 1 << QW;
    localparam int CW      = (SAMPLE_BITS > MAG_BITS + 1) ? SAMPLE_BITS : MAG_BITS + 1;
    localparam logic [CW-1:0] LIMIT = CW'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic [MAG_BITS-1:0] QEND = quarter_cos(QUARTER, TABLE_ADDR_BITS);

    // Quarter-wave table; the single entry at a quarter cycle is kept apart.
    logic [MAG_BITS-1:0] rom [QUARTER];
    for (genvar g = 0; g < QUARTER; g++)
    begin : g_rom
        localparam logic [MAG_BITS-1:0] V = quarter_cos(g, TABLE_ADDR_BITS);
        assign rom[g] = V;
    end

    logic                adv;
    logic [31:0]         phase_reg;
    logic [31:0]         phase_next;
    logic [31:0]         offset_reg;
    logic [31:0]         offset_next;
    logic [31:0]         sum;

    logic                v1_reg, v2_reg, v3_reg, v4_reg, vo_reg;
    logic                l1_reg, l2_reg, l3_reg, l4_reg, lo_reg;
    logic [A-1:0]        addr_reg;
    logic [A-1:0]        addr_next;
    logic [QW-1:0]       idx_reg;
    logic [QW-1:0]       idx_next;
    logic                end_reg;
    logic                end_next;
    logic                n2_reg, n3_reg, n4_reg;
    logic                neg_next;
    logic [MAG_BITS-1:0] mag_reg;
    logic [MAG_BITS-1:0] mag_next;
    logic [MAG_BITS-1:0] prod_reg;
    logic [MAG_BITS-1:0] prod_next;
    logic [2*MAG_BITS-1:0] prod_full;
    logic [CW-1:0]       prod_ext;
    logic [CW-1:0]       clamped;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [SAMPLE_BITS-1:0] sample_next;
    logic [1:0]          quad;
    logic [QW-1:0]       rem;

    // The whole pipe moves together whenever the output register can take a value.
    assign adv        = !vo_reg || !out_stall;
    assign stat.ready = adv;

    always_comb
    begin
        case ({cmd.first_bit, cmd.second_bit})
            2'b00:   offset_next = OFFSET_00;
            2'b01:   offset_next = OFFSET_01;
            2'b10:   offset_next = OFFSET_10;
            default: offset_next = OFFSET_11;
        endcase
    end

    assign sum        = phase_reg + offset_reg;
    assign addr_next  = sum[31 -: A];
    assign phase_next = phase_reg + phase_step;

    assign quad     = addr_reg[A-1 -: 2];
    assign rem      = addr_reg[QW-1:0];
    assign neg_next = (quad == 2'd1) || (quad == 2'd2);
    assign idx_next = quad[0] ? (QW'(0) - rem) : rem;
    assign end_next = quad[0] && (rem == '0);

    assign mag_next  = end_reg ? QEND : rom[idx_reg];
    assign prod_full = amplitude * mag_reg;
    assign prod_next = prod_full[2*MAG_BITS-1:MAG_BITS];

    assign prod_ext    = CW'(prod_reg);
    assign clamped     = (prod_ext > LIMIT) ? LIMIT : prod_ext;
    assign sample_next = n4_reg ? (SAMPLE_BITS'(0) - clamped[SAMPLE_BITS-1:0])
                                : clamped[SAMPLE_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            vo_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.issue)
                phase_reg <= phase_next;
            if (adv)
            begin
                v1_reg <= cmd.issue;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
                v4_reg <= v3_reg;
                vo_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            offset_reg <= offset_next;
        if (adv)
        begin
            addr_reg   <= addr_next;
            l1_reg     <= cmd.last;
            idx_reg    <= idx_next;
            end_reg    <= end_next;
            n2_reg     <= neg_next;
            l2_reg     <= l1_reg;
            mag_reg    <= mag_next;
            n3_reg     <= n2_reg;
            l3_reg     <= l2_reg;
            prod_reg   <= prod_next;
            n4_reg     <= n3_reg;
            l4_reg     <= l3_reg;
            sample_reg <= sample_next;
            lo_reg     <= l4_reg;
        end
    end

    assign out_valid   = vo_reg;
    assign sample      = $signed(sample_reg);
    assign last_sample = lo_reg;

    a_issue_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> stat.ready)
        else $error("sample issued while the pipe is stalled");

    a_sample_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (sample_reg != {1'b1, {(SAMPLE_BITS-1){1'b0}}}))
        else $error("sample outside the symmetric range");

    a_phase_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.issue |=> $stable(phase_reg))
        else $error("phase moved without an issued sample");

endmodule
